>>> hdl/csm_pkg.sv
// Package for the cell stack with in-stack marks.
// Holds field widths, default sizes, request and status codes, controller
// states and the command and flag bundles shared by the controller and datapath.
package csm_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DefStackDepth = 256;
  localparam int DefMazeDim    = 16;

  // Fixed field widths of the stream words.
  localparam int RowW     = 4;
  localparam int ColW     = 4;
  localparam int IdxW     = 8;
  localparam int SizeW    = 9;
  localparam int ReqW     = 2;
  localparam int StatW    = 3;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  // Request kinds carried on the input tuser.
  typedef enum logic [ReqW-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_DONE  = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_DUP   = 3'd3,
    ST_INDEX = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT,
    S_RESULT
  } state_e;

  // Read address sources of the stack memory.
  typedef enum logic [1:0] {
    RD_TOP,
    RD_INDEX,
    RD_PTR1,
    RD_PTR2
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    ptr_load;
    logic    set_status;
    status_e status_code;
    logic    push_store;
    logic    push_mark;
    logic    capture_out;
    logic    clear_solve;
    logic    shift_write;
    logic    dec_count;
    logic    load_out;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    req_e req;
    logic empty;
    logic full;
    logic dup;
    logic idx_big;
    logic more1;
    logic more2;
    logic out_free;
  } flags_t;

endpackage

>>> hdl/csm_ctrl.sv
// Controller state machine of the cell stack.
// Depends on csm_pkg for states, request and status codes and the command bundle.
module csm_ctrl
  import csm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   s_valid_i,
  output logic   s_ready_o,
  input  flags_t flags_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.set_status  = 1'b1;
        cmd_o.status_code = ST_DONE;
        state_d           = S_RESULT;
        unique case (flags_i.req)
          REQ_PUSH: begin
            cmd_o.push_mark = 1'b1;
            if (flags_i.full) begin
              cmd_o.status_code = ST_FULL;
            end else if (flags_i.dup) begin
              cmd_o.status_code = ST_DUP;
            end else begin
              cmd_o.push_store = 1'b1;
            end
          end
          REQ_POP: begin
            if (flags_i.empty) begin
              cmd_o.status_code = ST_EMPTY;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_TOP;
              state_d      = S_READ;
            end
          end
          REQ_REMOVE: begin
            if (flags_i.empty) begin
              cmd_o.status_code = ST_EMPTY;
            end else if (flags_i.idx_big) begin
              cmd_o.status_code = ST_INDEX;
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_sel   = RD_INDEX;
              cmd_o.ptr_load = 1'b1;
              state_d        = S_READ;
            end
          end
          REQ_NOP: begin
            cmd_o.status_code = ST_DONE;
          end
          default: begin
            cmd_o.status_code = ST_DONE;
          end
        endcase
      end
      S_READ: begin
        // The read word is the popped or removed cell.
        cmd_o.capture_out = 1'b1;
        if (flags_i.req == REQ_POP) begin
          cmd_o.clear_solve = 1'b1;
          cmd_o.dec_count   = 1'b1;
          state_d           = S_RESULT;
        end else if (flags_i.more1) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR1;
          state_d      = S_SHIFT;
        end else begin
          cmd_o.dec_count = 1'b1;
          state_d         = S_RESULT;
        end
      end
      S_SHIFT: begin
        // Move one entry down per cycle while the next one is fetched.
        cmd_o.shift_write = 1'b1;
        if (flags_i.more2) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR2;
        end else begin
          cmd_o.dec_count = 1'b1;
          state_d         = S_RESULT;
        end
      end
      S_RESULT: begin
        if (flags_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/csm_datapath.sv
// Datapath of the cell stack: request registers, stack memory, count, shift
// pointer, the two mark maps and the output word register. Depends on csm_pkg.
module csm_datapath
  import csm_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int MAZE_DIM    = DefMazeDim
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  req_e                req_type_i,
  input  logic [RowW-1:0]     cell_row_i,
  input  logic [ColW-1:0]     cell_column_i,
  input  logic                generating_mode_i,
  input  logic [IdxW-1:0]     remove_index_i,
  input  cmd_t                cmd_i,
  output flags_t              flags_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o
);

  localparam int AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW      = $clog2(STACK_DEPTH + 1);
  localparam int EffDim  = (MAZE_DIM < (1 << RowW)) ? MAZE_DIM : (1 << RowW);
  localparam int MapSize = EffDim * EffDim;
  localparam int SW      = $clog2(MapSize);
  localparam int PadW    = OutDataW - (RowW + ColW + StatW + SizeW + 2);

  // Request registers.
  req_e            req_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic            gen_q;
  logic [IdxW-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      row_q <= cell_row_i;
      col_q <= cell_column_i;
      gen_q <= generating_mode_i;
      idx_q <= remove_index_i;
    end
  end

  // Stack memory: one write and one registered read per cycle.
  logic [RowW+ColW-1:0] mem [STACK_DEPTH];
  logic [RowW+ColW-1:0] rdata_q;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [RowW+ColW-1:0] wr_data;
  logic                 wr_en;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        ptr_q;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_TOP:   rd_addr = AW'(count_q - 1'b1);
      RD_INDEX: rd_addr = AW'(idx_q);
      RD_PTR1:  rd_addr = ptr_q + AW'(1);
      RD_PTR2:  rd_addr = ptr_q + AW'(2);
      default:  rd_addr = ptr_q;
    endcase
  end

  assign wr_en   = cmd_i.push_store | cmd_i.shift_write;
  assign wr_addr = cmd_i.push_store ? AW'(count_q) : ptr_q;
  assign wr_data = cmd_i.push_store ? {row_q, col_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Entry count and shift pointer.
  always_comb begin
    count_d = count_q;
    if (cmd_i.push_store) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.dec_count) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr_load) begin
      ptr_q <= AW'(idx_q);
    end else if (cmd_i.shift_write) begin
      ptr_q <= ptr_q + AW'(1);
    end
  end

  // Mark maps, one bit per maze cell, cleared by reset.
  logic [MapSize-1:0] solve_q, build_q;
  logic               req_valid, pop_valid;
  logic [SW-1:0]      req_slot, pop_slot;
  logic [RowW-1:0]    pop_row;
  logic [ColW-1:0]    pop_col;

  assign pop_row   = rdata_q[RowW+ColW-1:ColW];
  assign pop_col   = rdata_q[ColW-1:0];
  assign req_valid = (32'(row_q) < MAZE_DIM) && (32'(col_q) < MAZE_DIM);
  assign pop_valid = (32'(pop_row) < MAZE_DIM) && (32'(pop_col) < MAZE_DIM);
  assign req_slot  = SW'(32'(row_q) * EffDim + 32'(col_q));
  assign pop_slot  = SW'(32'(pop_row) * EffDim + 32'(pop_col));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solve_q <= '0;
      build_q <= '0;
    end else begin
      if (cmd_i.push_mark && req_valid) begin
        if (gen_q) begin
          build_q[req_slot] <= 1'b1;
        end else begin
          solve_q[req_slot] <= 1'b1;
        end
      end
      if (cmd_i.clear_solve && pop_valid) begin
        solve_q[pop_slot] <= 1'b0;
      end
    end
  end

  // Result fields of the item in progress.
  logic [RowW-1:0] res_row_q;
  logic [ColW-1:0] res_col_q;
  status_e         res_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      res_row_q <= '0;
      res_col_q <= '0;
    end else if (cmd_i.capture_out) begin
      res_row_q <= pop_row;
      res_col_q <= pop_col;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status_code;
    end
  end

  // Output word register; it frees the controller for the next item.
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                is_full, is_empty;

  assign is_full  = (count_q == CW'(STACK_DEPTH));
  assign is_empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_data_q <= {{PadW{1'b0}}, is_empty, is_full, SizeW'(count_q),
                   res_status_q, res_col_q, res_row_q};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  // Flags for the controller.
  always_comb begin
    flags_o          = '0;
    flags_o.req      = req_q;
    flags_o.empty    = is_empty;
    flags_o.full     = is_full;
    flags_o.dup      = gen_q && req_valid && build_q[req_slot];
    flags_o.idx_big  = (CW + IdxW)'(idx_q) >= (CW + IdxW)'(count_q);
    flags_o.more1    = ((CW + 1)'(ptr_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
    flags_o.more2    = ((CW + 1)'(ptr_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);
    flags_o.out_free = !m_valid_q || m_ready_i;
  end

endmodule

>>> hdl/cell_stack_with_marks_unit.sv
// Top level of the cell stack with in-stack marks.
// Depends on csm_pkg, csm_ctrl and csm_datapath.
//
// A bounded stack of maze cells with a solving-map and a generation-map mark
// per cell, driven by one request word and answering with one result word.
// Each request occupies the block from acceptance until its result is moved
// into the output register: a push, an ignored request or the unused request
// code passes through the execute and result states, a pop also through the
// read state, and a remove also through the read state and a shift state for
// each entry above the removed one. The stack memory with one write and one
// registered read per cycle moves one entry per cycle while the entries above
// the removed one shift down. The mark maps are flip-flops cleared by reset,
// so no clearing pass follows reset. The output register lets the next request
// be taken while a result still waits downstream.
module cell_stack_with_marks_unit
  import csm_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int MAZE_DIM    = DefMazeDim
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [3:0] cell_row, [7:4] cell_column, [8] generating_mode,
  // [16:9] remove_index, [23:17] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] req_type
  input  logic [ReqW-1:0]     s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [3:0] out_row, [7:4] out_column, [10:8] status, [19:11] stack_size,
  // [20] is_full, [21] is_empty, [23:22] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cmd_t   cmd;
  flags_t flags;

  csm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .flags_i   (flags),
    .cmd_o     (cmd)
  );

  csm_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAZE_DIM    (MAZE_DIM)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_type_i        (req_e'(s_axis_tuser_i)),
    .cell_row_i        (s_axis_tdata_i[3:0]),
    .cell_column_i     (s_axis_tdata_i[7:4]),
    .generating_mode_i (s_axis_tdata_i[8]),
    .remove_index_i    (s_axis_tdata_i[16:9]),
    .cmd_i             (cmd),
    .flags_o           (flags),
    .m_valid_o         (m_axis_tvalid_o),
    .m_ready_i         (m_axis_tready_i),
    .m_data_o          (m_axis_tdata_o)
  );

endmodule
